FILE: design/mqpd_pkg.sv
// ----------------------------------------------------------------------------
// mqpd_pkg
// Shared types, field widths, codes and parameter defaults for the
// multi-queue priority deque.
// ----------------------------------------------------------------------------
package mqpd_pkg;

  // Parameter defaults.
  localparam int NUM_QUEUES_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 5;
  localparam int TAG_BITS_DEF    = 16;

  // Fixed widths of the transaction fields.
  localparam int QIDX_W    = 5;
  localparam int TAG_W     = 16;
  localparam int CODE_W    = 2;
  localparam int LEN_OUT_W = 3;

  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_TAKE = 1'b1
  } func_t;

  typedef enum logic [CODE_W-1:0] {
    RES_DONE  = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } code_t;

  // Kind of row update broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_ADD_TAIL = 2'd0,
    OP_ADD_HEAD = 2'd1,
    OP_TAKE     = 2'd2
  } op_t;

  typedef struct packed {
    logic commit;
    op_t  op;
  } cell_ctrl_t;

endpackage

FILE: design/mqpd_req_if.sv
// ----------------------------------------------------------------------------
// mqpd_req_if
// Request channel: add or take on one class queue.
// ----------------------------------------------------------------------------
interface mqpd_req_if;

  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [mqpd_pkg::QIDX_W-1:0]   queue_index;
  logic [mqpd_pkg::TAG_W-1:0]    entry_tag;
  logic                          urgent;

  modport source (
    output valid, func, queue_index, entry_tag, urgent,
    input  ready
  );

  modport sink (
    input  valid, func, queue_index, entry_tag, urgent,
    output ready
  );

endinterface

FILE: design/mqpd_rsp_if.sv
// ----------------------------------------------------------------------------
// mqpd_rsp_if
// Response channel: outcome of one request.
// ----------------------------------------------------------------------------
interface mqpd_rsp_if;

  logic                            valid;
  logic                            ready;
  logic [mqpd_pkg::CODE_W-1:0]     result_code;
  logic [mqpd_pkg::TAG_W-1:0]      taken_tag;
  logic                            taken_urgent;
  logic [mqpd_pkg::LEN_OUT_W-1:0]  queue_length;

  modport source (
    output valid, result_code, taken_tag, taken_urgent, queue_length,
    input  ready
  );

  modport sink (
    input  valid, result_code, taken_tag, taken_urgent, queue_length,
    output ready
  );

endinterface

FILE: design/mqpd_ram.sv
// ----------------------------------------------------------------------------
// mqpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mqpd_cell.sv
// ----------------------------------------------------------------------------
// mqpd_cell
// One slot position of every queue. Holds slot IDX of all queues in a RAM
// and, on a commit, takes a new entry or its neighbor's entry.
// ----------------------------------------------------------------------------
module mqpd_cell #(
  parameter int IDX        = 0,
  parameter int NUM_QUEUES = mqpd_pkg::NUM_QUEUES_DEF,
  parameter int EW         = mqpd_pkg::TAG_BITS_DEF + 1,
  parameter int LEN_W      = 3,
  localparam int AW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic                 clk,
  input  logic [AW-1:0]        raddr,
  input  logic [AW-1:0]        waddr,
  input  mqpd_pkg::cell_ctrl_t ctrl,
  input  logic [LEN_W-1:0]     len,
  input  logic [EW-1:0]        new_entry,
  input  logic [EW-1:0]        left_entry,
  input  logic [EW-1:0]        right_entry,
  output logic [EW-1:0]        entry
);

  logic          we;
  logic [EW-1:0] wdata;

  always_comb begin
    we    = 1'b0;
    wdata = new_entry;
    case (ctrl.op)
      mqpd_pkg::OP_ADD_TAIL: begin
        we = ctrl.commit && (len == LEN_W'(IDX));
      end
      mqpd_pkg::OP_ADD_HEAD: begin
        // Urgent insert: everything up to the old tail moves one slot back.
        we    = ctrl.commit && (LEN_W'(IDX) <= len);
        wdata = (IDX == 0) ? new_entry : left_entry;
      end
      mqpd_pkg::OP_TAKE: begin
        we    = ctrl.commit && (LEN_W'(IDX + 1) < len);
        wdata = right_entry;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  mqpd_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_QUEUES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (entry)
  );

endmodule

FILE: design/multi_queue_priority_deque_top.sv
// ----------------------------------------------------------------------------
// multi_queue_priority_deque_top
// Bank of bounded per-class queues with tail append, urgent head insert and
// head take. Slot k of all queues lives in cell k; cells shift into each other.
// ----------------------------------------------------------------------------
// A request is accepted only in ST_IDLE, where the addressed queue row is
// read from the cell RAMs; ST_EXEC writes the row and registers the response,
// so no new request is taken until it commits; a stalled response delays that.
// Reset: queue lengths read as zero at once through per-queue valid flops;
// entries are undefined until written, so there is no clearing pass.
// ----------------------------------------------------------------------------
module multi_queue_priority_deque_top #(
  parameter int NUM_QUEUES  = mqpd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqpd_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = mqpd_pkg::TAG_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mqpd_req_if.sink   req,
  mqpd_rsp_if.source rsp
);

  localparam int AW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int EW     = TAG_BITS + 1;
  localparam int QX_W   = mqpd_pkg::QIDX_W + 8;
  localparam int TX_W   = TAG_BITS + mqpd_pkg::TAG_W;
  localparam int LX_W   = LEN_W + mqpd_pkg::LEN_OUT_W;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Latched request.
  logic               func_take;
  logic               in_range;
  logic [AW-1:0]      qaddr;
  logic [EW-1:0]      new_entry;

  logic [NUM_QUEUES-1:0] qvalid;

  logic [QX_W-1:0]    req_q_ext;
  logic [AW-1:0]      req_addr;
  logic               req_in_range;
  logic [TX_W-1:0]    req_tag_ext;
  logic [AW-1:0]      raddr;

  logic [LEN_W-1:0]   len_rdata;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic               len_we;
  logic               commit;
  logic               out_free;

  logic [mqpd_pkg::CODE_W-1:0] code_next;
  logic [EW-1:0]      head_next;
  logic [TX_W-1:0]    head_tag_ext;
  logic [LX_W-1:0]    len_ext;

  mqpd_pkg::cell_ctrl_t ctrl;

  logic [QUEUE_DEPTH-1:0][EW-1:0] cell_entry;

  assign req_q_ext    = QX_W'(req.queue_index);
  assign req_addr     = req_q_ext[AW-1:0];
  assign req_in_range = (req_q_ext < QX_W'(NUM_QUEUES));
  assign req_tag_ext  = TX_W'(req.entry_tag);

  assign req.ready = (state == ST_IDLE);
  assign raddr     = (state == ST_IDLE) ? req_addr : qaddr;
  assign out_free  = !rsp.valid || rsp.ready;
  assign commit    = (state == ST_EXEC) && out_free;

  assign len = qvalid[qaddr] ? len_rdata : '0;

  always_comb begin
    code_next = mqpd_pkg::RES_DONE;
    head_next = '0;
    len_next  = len;
    len_we    = 1'b0;
    ctrl.op   = mqpd_pkg::OP_TAKE;
    if (!func_take) begin
      ctrl.op = new_entry[EW-1] ? mqpd_pkg::OP_ADD_HEAD : mqpd_pkg::OP_ADD_TAIL;
      if (!in_range) begin
        code_next = mqpd_pkg::RES_FULL;
        len_next  = '0;
      end else if (len >= LEN_W'(QUEUE_DEPTH)) begin
        code_next = mqpd_pkg::RES_FULL;
      end else begin
        len_next = len + LEN_W'(1);
        len_we   = 1'b1;
      end
    end else begin
      if (!in_range || (len == '0)) begin
        code_next = mqpd_pkg::RES_EMPTY;
        len_next  = '0;
      end else begin
        head_next = cell_entry[0];
        len_next  = len - LEN_W'(1);
        len_we    = 1'b1;
      end
    end
    ctrl.commit = commit && len_we;
  end

  assign head_tag_ext = TX_W'(head_next[TAG_BITS-1:0]);
  assign len_ext      = LX_W'(len_next);

  // Row of cells: cell k holds slot k of every queue.
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [EW-1:0] left_entry;
    logic [EW-1:0] right_entry;

    if (k == 0) begin : g_first
      assign left_entry = new_entry;
    end else begin : g_mid_l
      assign left_entry = cell_entry[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid_r
      assign right_entry = cell_entry[k+1];
    end

    mqpd_cell #(
      .IDX        (k),
      .NUM_QUEUES (NUM_QUEUES),
      .EW         (EW),
      .LEN_W      (LEN_W)
    ) u_cell (
      .clk         (clk),
      .raddr       (raddr),
      .waddr       (qaddr),
      .ctrl        (ctrl),
      .len         (len),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (cell_entry[k])
    );
  end

  mqpd_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NUM_QUEUES)
  ) u_len_ram (
    .clk   (clk),
    .we    (ctrl.commit),
    .waddr (qaddr),
    .wdata (len_next),
    .raddr (raddr),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      qvalid    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (ctrl.commit) begin
        qvalid[qaddr] <= 1'b1;
      end

      if (commit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      func_take <= (req.func == mqpd_pkg::FUNC_TAKE);
      in_range  <= req_in_range;
      qaddr     <= req_addr;
      new_entry <= {req.urgent, req_tag_ext[TAG_BITS-1:0]};
    end
    if (commit) begin
      rsp.result_code  <= code_next;
      rsp.taken_tag    <= head_tag_ext[mqpd_pkg::TAG_W-1:0];
      rsp.taken_urgent <= head_next[EW-1];
      rsp.queue_length <= len_ext[mqpd_pkg::LEN_OUT_W-1:0];
    end
  end

endmodule
